// File: hdl/bfss_pkg.sv
// Shared types, stream widths and the control program of the file send sequencer.
package bfss_pkg;

  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_NAME  = 4'd1,
    PH_MAXB  = 4'd2,
    PH_FSIZE = 4'd3,
    PH_INDEX = 4'd4,
    PH_BSIZE = 4'd5,
    PH_DATA  = 4'd6,
    PH_DONE  = 4'd7,
    PH_ERROR = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    SUB_NONE  = 3'd0,
    SUB_NAME  = 3'd1,
    SUB_FSIZE = 3'd2,
    SUB_MAXB  = 3'd3,
    SUB_INDEX = 3'd4,
    SUB_BSIZE = 3'd5,
    SUB_DATA  = 3'd6
  } subindex_t;

  typedef enum logic [1:0] {
    CFG_TARGET_NODE = 2'd0,
    CFG_NAME_LENGTH = 2'd1,
    CFG_BUFFER_BASE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_START    = 1'b0,
    REQ_COMPLETE = 1'b1
  } req_type_t;

  // Program step addresses
  typedef enum logic [3:0] {
    ST_WAIT, ST_START, ST_REFUSE, ST_IGNORE, ST_FAIL, ST_STEP, ST_MAXB,
    ST_DIV, ST_SPLIT, ST_MUL, ST_PROG, ST_DATA, ST_ISSUE, ST_EMIT
  } step_t;

  // Datapath action of one control word
  typedef enum logic [3:0] {
    UOP_NONE, UOP_CAPTURE, UOP_START, UOP_REFUSE, UOP_FAIL, UOP_STEP, UOP_MAXB,
    UOP_DIV, UOP_SPLIT, UOP_MUL, UOP_PROG, UOP_DATA, UOP_ISSUE
  } uop_t;

  // Sequencing of one control word
  typedef enum logic [2:0] {
    SEQ_NEXT,      // go to next
    SEQ_DISPATCH,  // wait for a word, then jump by request and phase
    SEQ_LOOP,      // stay until the divider count runs out, then next
    SEQ_BRANCH,    // jump to alt when the condition holds, else next
    SEQ_HOLD       // stay until the result word is taken, then next
  } seq_t;

  typedef struct packed {
    uop_t  uop;
    seq_t  seq;
    step_t next;
    step_t alt;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '{uop: UOP_NONE, seq: SEQ_NEXT, next: ST_WAIT, alt: ST_WAIT};
    unique case (s)
      ST_WAIT:   c = '{uop: UOP_CAPTURE, seq: SEQ_DISPATCH, next: ST_WAIT,  alt: ST_WAIT};
      ST_START:  c = '{uop: UOP_START,   seq: SEQ_NEXT,     next: ST_ISSUE, alt: ST_WAIT};
      ST_REFUSE: c = '{uop: UOP_REFUSE,  seq: SEQ_NEXT,     next: ST_EMIT,  alt: ST_WAIT};
      ST_IGNORE: c = '{uop: UOP_NONE,    seq: SEQ_NEXT,     next: ST_EMIT,  alt: ST_WAIT};
      ST_FAIL:   c = '{uop: UOP_FAIL,    seq: SEQ_NEXT,     next: ST_EMIT,  alt: ST_WAIT};
      ST_STEP:   c = '{uop: UOP_STEP,    seq: SEQ_NEXT,     next: ST_ISSUE, alt: ST_WAIT};
      ST_MAXB:   c = '{uop: UOP_MAXB,    seq: SEQ_BRANCH,   next: ST_DIV,   alt: ST_EMIT};
      ST_DIV:    c = '{uop: UOP_DIV,     seq: SEQ_LOOP,     next: ST_SPLIT, alt: ST_WAIT};
      ST_SPLIT:  c = '{uop: UOP_SPLIT,   seq: SEQ_NEXT,     next: ST_ISSUE, alt: ST_WAIT};
      ST_MUL:    c = '{uop: UOP_MUL,     seq: SEQ_NEXT,     next: ST_PROG,  alt: ST_WAIT};
      ST_PROG:   c = '{uop: UOP_PROG,    seq: SEQ_BRANCH,   next: ST_ISSUE, alt: ST_EMIT};
      ST_DATA:   c = '{uop: UOP_DATA,    seq: SEQ_BRANCH,   next: ST_ISSUE, alt: ST_EMIT};
      ST_ISSUE:  c = '{uop: UOP_ISSUE,   seq: SEQ_NEXT,     next: ST_EMIT,  alt: ST_WAIT};
      ST_EMIT:   c = '{uop: UOP_NONE,    seq: SEQ_HOLD,     next: ST_WAIT,  alt: ST_WAIT};
      default:   c = '{uop: UOP_NONE,    seq: SEQ_NEXT,     next: ST_WAIT,  alt: ST_WAIT};
    endcase
    return c;
  endfunction

  function automatic logic is_settled(phase_t ph);
    return (ph == PH_IDLE) || (ph == PH_DONE) || (ph == PH_ERROR);
  endfunction

  // Entry step of the program for an accepted word
  function automatic step_t dispatch(req_type_t req, logic ok, phase_t ph);
    step_t s;
    s = ST_FAIL;
    if (req == REQ_START) begin
      s = is_settled(ph) ? ST_START : ST_REFUSE;
    end else if (is_settled(ph)) begin
      s = ST_IGNORE;
    end else if (!ok) begin
      s = ST_FAIL;
    end else begin
      unique case (ph)
        PH_NAME, PH_FSIZE, PH_BSIZE: s = ST_STEP;
        PH_MAXB:                     s = ST_MAXB;
        PH_INDEX:                    s = ST_MUL;
        PH_DATA:                     s = ST_DATA;
        default:                     s = ST_FAIL;
      endcase
    end
    return s;
  endfunction

endpackage

// File: hdl/block_file_send_sequencer_unit.sv
// Top level: microcoded sequencer that sends a file as a chain of dictionary requests.
//
//  channel   | group       | tdata (low bit up)                          | tuser
//  ----------+-------------+---------------------------------------------+------------------
//  request   | s_axis_*    | file_length, transfer_ok, read_value        | req_type
//  result    | m_axis_*    | entry_subindex, byte_count, data_address,   | request_valid,
//            |             | segmented_mode, progress_bytes, phase_code, | request_is_read,
//            |             | start_refused                               | progress_valid
//  config    | cfg_*       | write enable, register index, 32-bit data   | -
//
// One word is worked at a time by the microcoded program stepper.
// A block index completion adds a multiply and a progress step before the request, and a
// nonzero max block completion first runs the 32 steps of the divider, then the split.
// The result word holds in the output register until taken; no word is accepted meanwhile.
// Reset (synchronous) returns to idle with no transfer; no clearing pass is needed.
module block_file_send_sequencer_unit #(
  parameter int NAME_MAX = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // file_length[31:0], transfer_ok[32], read_value[64:33], zero pad
  input  logic [bfss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type[0]
  input  logic [bfss_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // entry_subindex[2:0], byte_count[34:3], data_address[66:35], segmented_mode[67],
  // progress_bytes[99:68], phase_code[103:100], start_refused[104], zero pad
  output logic [bfss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // request_valid[0], request_is_read[1], progress_valid[2]
  output logic [bfss_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [bfss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bfss_pkg::*;

  localparam logic [31:0] NameMaxW = 32'(NAME_MAX);

  // configuration; the node number belongs to the request layer and is not kept here
  logic [6:0]  name_length;
  logic [31:0] buffer_base;

  // sequencer
  step_t step, step_next;
  ctrl_t ctrl;
  logic  in_fire, out_fire, branch_cond;

  // captured input word
  logic [31:0] flen_q, rval_q;

  // transfer state
  phase_t      phase;
  logic [31:0] max_block, cur_block, full_blocks, tail_bytes, total_bytes;
  logic [31:0] block_offset;
  logic [63:0] prod;

  // divider
  logic [31:0] div_rem, div_quo;
  logic [4:0]  div_cnt;
  logic [32:0] div_trial, div_diff;

  // result register
  logic        res_rv, res_rd, res_seg, res_pv, res_refused;
  subindex_t   res_sub;
  logic [31:0] res_bytes, res_addr, res_prog;

  // combinational helpers
  logic [31:0] block_len, name_clamped, name_ext;
  logic [64:0] prog_sum;

  assign ctrl     = ucode(step);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign block_len = (cur_block < full_blocks) ? max_block : tail_bytes;
  assign name_ext  = {25'd0, name_length};
  assign prog_sum  = {1'b0, prod} + {33'd0, max_block};

  always_comb begin
    name_clamped = name_ext;
    if (name_ext == 32'd0) begin
      name_clamped = 32'd1;
    end else if (name_ext > NameMaxW) begin
      name_clamped = NameMaxW;
    end
  end

  assign div_trial = {div_rem, div_quo[31]};
  assign div_diff  = div_trial - {1'b0, max_block};

  always_comb begin
    branch_cond = 1'b0;
    unique case (ctrl.uop)
      UOP_MAXB: branch_cond = (rval_q == 32'd0);
      UOP_PROG: branch_cond = (cur_block == 32'hFFFF_FFFF);
      UOP_DATA: branch_cond = (cur_block == full_blocks);
      default:  branch_cond = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    step_next = step;
    unique case (ctrl.seq)
      SEQ_DISPATCH: begin
        if (in_fire) begin
          step_next = dispatch(req_type_t'(s_axis_tuser[0]), s_axis_tdata[32], phase);
        end
      end
      SEQ_LOOP:   step_next = (div_cnt == 5'd0) ? ctrl.next : step;
      SEQ_BRANCH: step_next = branch_cond ? ctrl.alt : ctrl.next;
      SEQ_HOLD:   step_next = m_axis_tready ? ctrl.next : step;
      default:    step_next = ctrl.next;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (ctrl.seq == SEQ_DISPATCH);
    m_axis_tvalid = (ctrl.seq == SEQ_HOLD);
  end

  assign m_axis_tdata = {7'd0, res_refused, phase, res_prog, res_seg, res_addr,
                         res_bytes, res_sub};
  assign m_axis_tuser = {res_pv, res_rd, res_rv};

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length <= 7'd1;
      buffer_base <= 32'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NAME_LENGTH) begin
        name_length <= cfg_data[6:0];
      end else if (cfg_index == CFG_BUFFER_BASE) begin
        buffer_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      unique case (ctrl.uop)
        UOP_START: phase <= PH_NAME;
        UOP_FAIL:  phase <= PH_ERROR;
        UOP_STEP:  phase <= phase_t'(phase + 4'd1);
        UOP_MAXB:  phase <= (rval_q == 32'd0) ? PH_ERROR : PH_FSIZE;
        UOP_PROG:  phase <= (cur_block == 32'hFFFF_FFFF) ? PH_ERROR : PH_BSIZE;
        UOP_DATA:  phase <= (cur_block == full_blocks) ? PH_DONE : PH_INDEX;
        default:   phase <= phase;
      endcase
    end
  end

  // datapath and result register
  always_ff @(posedge clk) begin
    unique case (ctrl.uop)
      UOP_CAPTURE: begin
        if (in_fire) begin
          flen_q      <= s_axis_tdata[31:0];
          rval_q      <= s_axis_tdata[64:33];
          res_rv      <= 1'b0;
          res_rd      <= 1'b0;
          res_seg     <= 1'b0;
          res_pv      <= 1'b0;
          res_refused <= 1'b0;
          res_sub     <= SUB_NONE;
          res_bytes   <= 32'd0;
          res_addr    <= 32'd0;
          res_prog    <= 32'd0;
        end
      end
      UOP_START: begin
        max_block   <= 32'd0;
        cur_block   <= 32'd0;
        full_blocks <= 32'd0;
        tail_bytes  <= 32'd0;
        total_bytes <= flen_q;
      end
      UOP_REFUSE: res_refused <= 1'b1;
      UOP_MAXB: begin
        max_block <= rval_q;
        div_rem   <= 32'd0;
        div_quo   <= total_bytes;
        div_cnt   <= 5'd31;
      end
      UOP_DIV: begin
        // one restoring step: shift in the next dividend bit, subtract when it fits
        if (!div_diff[32]) begin
          div_rem <= div_diff[31:0];
        end else begin
          div_rem <= div_trial[31:0];
        end
        div_quo <= {div_quo[30:0], ~div_diff[32]};
        div_cnt <= div_cnt - 5'd1;
      end
      UOP_SPLIT: begin
        full_blocks <= div_quo;
        tail_bytes  <= div_rem;
      end
      UOP_MUL: begin
        cur_block <= rval_q;
        prod      <= {32'd0, rval_q} * {32'd0, max_block};
      end
      UOP_PROG: begin
        block_offset <= prod[31:0];
        res_pv       <= 1'b1;
        res_prog     <= (prog_sum > {33'd0, total_bytes}) ? total_bytes : prog_sum[31:0];
      end
      UOP_ISSUE: begin
        unique case (phase)
          PH_NAME: begin
            res_rv    <= 1'b1;
            res_sub   <= SUB_NAME;
            res_bytes <= name_clamped;
            res_seg   <= 1'b1;
          end
          PH_MAXB: begin
            res_rv  <= 1'b1;
            res_rd  <= 1'b1;
            res_sub <= SUB_MAXB;
          end
          PH_FSIZE: begin
            res_rv    <= 1'b1;
            res_sub   <= SUB_FSIZE;
            res_bytes <= total_bytes;
          end
          PH_INDEX: begin
            res_rv  <= 1'b1;
            res_rd  <= 1'b1;
            res_sub <= SUB_INDEX;
          end
          PH_BSIZE: begin
            res_rv    <= 1'b1;
            res_sub   <= SUB_BSIZE;
            res_bytes <= block_len;
          end
          PH_DATA: begin
            res_rv    <= 1'b1;
            res_sub   <= SUB_DATA;
            res_bytes <= block_len;
            res_addr  <= buffer_base + block_offset;
            res_seg   <= 1'b1;
          end
          default: res_rv <= 1'b0;
        endcase
      end
      default: begin
        // hold
      end
    endcase
  end

endmodule

// File: hdl/bfss_checker.sv
// Port-level checks for the file send sequencer and their binding to the top level.
module bfss_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [bfss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [bfss_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import bfss_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // one word in flight: no intake while a result is offered
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // an accepted word blocks intake until its result is delivered
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  // no request means no entry and no byte count
  a_no_req_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[2:0] == SUB_NONE
      && m_axis_tdata[34:3] == 32'd0)
    else $error("request fields set without a request");

  // progress count only with its valid flag
  a_prog_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[99:68] == 32'd0)
    else $error("progress count without progress flag");

endmodule

bind block_file_send_sequencer_unit bfss_checker u_bfss_checker (.*);

// File: tb/sv/bfss_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the file send sequencer: predicts each result word and compares it.
module bfss_result_checker #(
  parameter int NAME_MAX = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // file_length[31:0], transfer_ok[32], read_value[64:33], zero pad
  input  logic [bfss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type[0]
  input  logic [bfss_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // entry_subindex[2:0], byte_count[34:3], data_address[66:35], segmented_mode[67],
  // progress_bytes[99:68], phase_code[103:100], start_refused[104], zero pad
  input  logic [bfss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // request_valid[0], request_is_read[1], progress_valid[2]
  input  logic [bfss_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [bfss_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fails,
  output int                                pending
);
  import bfss_pkg::*;

  typedef struct packed {
    logic        req_valid;
    logic        is_read;
    subindex_t   sub;
    logic [31:0] byte_count;
    logic [31:0] addr;
    logic        seg;
    logic        prog_valid;
    logic [31:0] prog_bytes;
    phase_t      phase;
    logic        refused;
  } reply_t;

  // mirrored registers
  logic [6:0]  node_reg;
  logic [6:0]  name_len_reg;
  logic [31:0] base_reg;

  // mirrored transfer state
  phase_t      ph;
  logic [31:0] max_blk;
  logic [31:0] cur_blk;
  logic [31:0] full_cnt;
  logic [31:0] tail_len;
  logic [31:0] total_len;

  reply_t pending_replies[$];

  initial begin
    fails   = 0;
    pending = 0;
  end

  function automatic logic [31:0] block_len();
    return (cur_blk < full_cnt) ? max_blk : tail_len;
  endfunction

  // Fill in the request that the phase just entered sends out.
  function automatic reply_t attach_request(reply_t r);
    int unsigned n;
    n = 32'(name_len_reg);
    if (n < 1) n = 1;
    if (n > NAME_MAX) n = NAME_MAX;
    case (ph)
      PH_NAME: begin
        r.req_valid  = 1'b1;
        r.sub        = SUB_NAME;
        r.byte_count = n;
        r.seg        = 1'b1;
      end
      PH_MAXB: begin
        r.req_valid = 1'b1;
        r.is_read   = 1'b1;
        r.sub       = SUB_MAXB;
      end
      PH_FSIZE: begin
        r.req_valid  = 1'b1;
        r.sub        = SUB_FSIZE;
        r.byte_count = total_len;
        full_cnt     = total_len / max_blk;
        tail_len     = total_len % max_blk;
      end
      PH_INDEX: begin
        r.req_valid = 1'b1;
        r.is_read   = 1'b1;
        r.sub       = SUB_INDEX;
      end
      PH_BSIZE: begin
        r.req_valid  = 1'b1;
        r.sub        = SUB_BSIZE;
        r.byte_count = block_len();
      end
      PH_DATA: begin
        r.req_valid  = 1'b1;
        r.sub        = SUB_DATA;
        r.byte_count = block_len();
        r.addr       = base_reg + cur_blk * max_blk;
        r.seg        = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic reply_t predict_reply(req_type_t req, logic [31:0] flen, logic ok,
                                           logic [31:0] rval);
    reply_t      r;
    logic        settled;
    logic        adv;
    logic [63:0] reach;
    r       = '0;
    adv     = 1'b0;
    settled = (ph == PH_IDLE) || (ph == PH_DONE) || (ph == PH_ERROR);
    if (req == REQ_START) begin
      if (!settled) begin
        r.refused = 1'b1;
      end else begin
        max_blk   = '0;
        cur_blk   = '0;
        full_cnt  = '0;
        tail_len  = '0;
        total_len = flen;
        ph        = PH_NAME;
        r         = attach_request(r);
      end
    end else if (!settled) begin
      if (!ok) begin
        ph = PH_ERROR;
      end else begin
        case (ph)
          PH_NAME, PH_FSIZE, PH_BSIZE: begin
            ph  = phase_t'(ph + 4'd1);
            adv = 1'b1;
          end
          PH_MAXB: begin
            max_blk = rval;
            if (rval == '0) begin
              ph = PH_ERROR;
            end else begin
              ph  = PH_FSIZE;
              adv = 1'b1;
            end
          end
          PH_INDEX: begin
            // progress is capped at the file size, product taken without wrap
            reach        = ({32'd0, rval} + 64'd1) * {32'd0, max_blk};
            cur_blk      = rval;
            r.prog_valid = 1'b1;
            r.prog_bytes = (reach > {32'd0, total_len}) ? total_len : reach[31:0];
            if (rval == 32'hFFFF_FFFF) begin
              ph = PH_ERROR;
            end else begin
              ph  = PH_BSIZE;
              adv = 1'b1;
            end
          end
          PH_DATA: begin
            ph  = (cur_blk == full_cnt) ? PH_DONE : PH_INDEX;
            adv = (ph == PH_INDEX);
          end
          default: ph = PH_ERROR;
        endcase
      end
      if (adv) r = attach_request(r);
    end
    r.phase = ph;
    return r;
  endfunction

  function automatic string show(reply_t r);
    return $sformatf("rv=%0b rd=%0b sub=%0d cnt=%h addr=%h seg=%0b pv=%0b prog=%h ph=%0d ref=%0b",
                     r.req_valid, r.is_read, r.sub, r.byte_count, r.addr, r.seg,
                     r.prog_valid, r.prog_bytes, r.phase, r.refused);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      node_reg     = '0;
      name_len_reg = 7'd1;
      base_reg     = '0;
      ph           = PH_IDLE;
      max_blk      = '0;
      cur_blk      = '0;
      full_cnt     = '0;
      tail_len     = '0;
      total_len    = '0;
      pending_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TARGET_NODE: node_reg     = cfg_data[6:0];
          CFG_NAME_LENGTH: name_len_reg = cfg_data[6:0];
          CFG_BUFFER_BASE: base_reg     = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_replies.push_back(predict_reply(req_type_t'(s_axis_tuser[0]),
                                                s_axis_tdata[31:0], s_axis_tdata[32],
                                                s_axis_tdata[64:33]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.req_valid  = m_axis_tuser[0];
        got.is_read    = m_axis_tuser[1];
        got.prog_valid = m_axis_tuser[2];
        got.sub        = subindex_t'(m_axis_tdata[2:0]);
        got.byte_count = m_axis_tdata[34:3];
        got.addr       = m_axis_tdata[66:35];
        got.seg        = m_axis_tdata[67];
        got.prog_bytes = m_axis_tdata[99:68];
        got.phase      = phase_t'(m_axis_tdata[103:100]);
        got.refused    = m_axis_tdata[104];
        if (pending_replies.size() == 0) begin
          fails++;
          if (fails <= 10) $display("[%0t] result word with none expected: %s", $time, show(got));
        end else begin
          want = pending_replies.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("[%0t] result word mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
    pending = pending_replies.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the file send sequencer: clock, reset, stimulus and verdict.
module tb_top;
  import bfss_pkg::*;

  localparam int NAME_MAX = 64;

  typedef struct packed {
    req_type_t   req;
    logic [31:0] flen;
    logic        ok;
    logic [31:0] rval;
  } word_t;

  logic                      clk;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_W-1:0]     s_axis_tdata;
  logic [IN_TUSER_W-1:0]     s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_W-1:0]    m_axis_tdata;
  logic [OUT_TUSER_W-1:0]    m_axis_tuser;
  logic                      cfg_we;
  logic [1:0]                cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  int                        fails;
  int                        pending;

  int  words_sent;
  bit  calm;
  int  hold_ask;
  int  hold_done;

  block_file_send_sequencer_unit #(.NAME_MAX(NAME_MAX)) dut (.*);

  bfss_result_checker #(.NAME_MAX(NAME_MAX)) u_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we, .cfg_index, .cfg_data, .fails, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stall per word, plus one long hold-off on request.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (hold_ask > hold_done) begin
        hold_done++;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  function automatic word_t start_word(logic [31:0] flen);
    word_t w;
    w.req  = REQ_START;
    w.flen = flen;
    w.ok   = 1'($urandom_range(0, 1));
    w.rval = $urandom;
    return w;
  endfunction

  function automatic word_t done_word(logic ok, logic [31:0] rval);
    word_t w;
    w.req  = REQ_COMPLETE;
    w.flen = $urandom;
    w.ok   = ok;
    w.rval = rval;
    return w;
  endfunction

  function automatic word_t noise_word();
    word_t w;
    w.req  = req_type_t'($urandom_range(0, 1));
    w.flen = $urandom;
    w.ok   = 1'($urandom_range(0, 1));
    w.rval = $urandom;
    return w;
  endfunction

  task automatic put_word(word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, w.rval, w.ok, w.flen};
    s_axis_tuser  <= w.req;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_script(ref word_t script[$]);
    foreach (script[i]) put_word(script[i]);
    script.delete();
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drop the offer and hold the sender until every result word is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic reconfigure();
    logic [6:0]  name_picks[8];
    logic [31:0] base_picks[4];
    name_picks = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd64, 7'd65, 7'd127, 7'($urandom)};
    base_picks = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, $urandom};
    drain();
    if ($urandom_range(0, 1)) write_reg(CFG_TARGET_NODE, $urandom_range(0, 127));
    write_reg(CFG_NAME_LENGTH, name_picks[$urandom_range(0, 7)]);
    write_reg(CFG_BUFFER_BASE, base_picks[$urandom_range(0, 3)]);
  endtask

  // A well-formed transfer with random sizes, sometimes broken at one step.
  task automatic plan_transfer(ref word_t script[$]);
    logic [31:0] blk;
    logic [31:0] tail;
    logic [63:0] flen64;
    int unsigned k;
    int          p;
    blk = $urandom >> $urandom_range(0, 31);
    if (blk == 0) blk = 1;
    k      = $urandom_range(0, 4);
    tail   = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom % blk;
    flen64 = {32'd0, blk} * k + tail;
    if (flen64 > 64'hFFFF_FFFF) begin
      k      = 0;
      flen64 = tail;
    end
    script.push_back(start_word(flen64[31:0]));
    script.push_back(done_word(1'b1, $urandom));
    script.push_back(done_word(1'b1, blk));
    script.push_back(done_word(1'b1, $urandom));
    // detour through a block index the file does not have
    if ($urandom_range(0, 4) == 0) begin
      script.push_back(done_word(1'b1, $urandom));
      script.push_back(done_word(1'b1, $urandom));
      script.push_back(done_word(1'b1, $urandom));
    end
    for (int unsigned i = 0; i <= k; i++) begin
      script.push_back(done_word(1'b1, i));
      script.push_back(done_word(1'b1, $urandom));
      script.push_back(done_word(1'b1, $urandom));
    end
    if ($urandom_range(0, 5) == 0) begin
      p = $urandom_range(1, script.size() - 1);
      case ($urandom_range(0, 5))
        0: script[p].ok = 1'b0;
        1: script.insert(p, start_word($urandom));
        2: script[p] = noise_word();
        3: script.delete(p);
        4: script[2].rval = '0;
        default: script[4].rval = 32'hFFFF_FFFF;
      endcase
    end
  endtask

  initial begin
    word_t script[$];
    int    next_cfg;
    bit    held;
    int    waited;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    words_sent    = 0;
    calm          = 1'b0;
    hold_ask      = 0;
    hold_done     = 0;
    held          = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // completion with nothing running
    script.push_back(done_word(1'b1, 32'hFFFF_FFFF));
    send_script(script);
    drain();
    write_reg(CFG_TARGET_NODE, 32'd127);
    write_reg(CFG_NAME_LENGTH, 32'd0);
    write_reg(CFG_BUFFER_BASE, 32'hFFFF_FFF0);

    // largest file and block, start while busy, block index of all ones
    script.push_back(start_word(32'hFFFF_FFFF));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, 32'hFFFF_FFFF));
    script.push_back(done_word(1'b1, '0));
    script.push_back(start_word('0));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, 32'hFFFF_FFFF));
    script.push_back(done_word(1'b1, '0));
    send_script(script);
    drain();
    write_reg(CFG_NAME_LENGTH, 32'd127);

    // zero block size, then a failed name write
    script.push_back(start_word(32'd5));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, '0));
    script.push_back(start_word(32'd10));
    script.push_back(done_word(1'b0, '0));
    send_script(script);
    drain();
    write_reg(CFG_NAME_LENGTH, 32'd64);
    write_reg(CFG_BUFFER_BASE, 32'h0000_1000);

    // index past the last block wraps the block offset, then a clean finish
    script.push_back(start_word(32'd7));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, 32'd3));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, 32'hA000_0000));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, 32'd2));
    script.push_back(done_word(1'b1, '0));
    script.push_back(done_word(1'b1, '0));
    send_script(script);

    next_cfg = words_sent + 100;
    while (words_sent < 1230) begin
      if (words_sent >= next_cfg) begin
        calm = 1'b0;
        reconfigure();
        next_cfg = words_sent + $urandom_range(80, 160);
      end
      if (!held && words_sent > 600) begin
        held = 1'b1;
        hold_ask++;
      end
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) script.push_back(noise_word());
      end else begin
        plan_transfer(script);
      end
      send_script(script);
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (50) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
